// ===== rtl/lr_pkg.sv =====
`default_nettype none

package lr_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam int WIN_BITS = 12;
   localparam logic [WIN_BITS-1:0] WIN_HEIGHT_RESET = 12'd500;

   typedef enum logic [0:0] {
      ACTION_LOAD = 1'b0,
      ACTION_STEP = 1'b1
   } action_type;

endpackage

`default_nettype wire

// ===== rtl/line_rasterizer_top.sv =====
// a request that makes a pixel shows it on rsp_valid in the cycle after it is accepted
// throughput: one request per cycle while req_stall is low; each step updates the line state
// req_stall is high only while a held pixel is stalled on the response side
// reset (synchronous, active high) clears the line state to idle and sets window_height to 500
`default_nettype none

module line_rasterizer_top #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,

   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_action,
   input  wire        [COORD_BITS-1:0]           req_x_start,
   input  wire        [COORD_BITS-1:0]           req_y_start,
   input  wire        [COORD_BITS-1:0]           req_x_end,
   input  wire        [COORD_BITS-1:0]           req_y_end,

   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic       [COORD_BITS-1:0]           rsp_pixel_x,
   output logic signed [COORD_BITS:0]            rsp_pixel_y,
   output logic                                  rsp_last_pixel,

   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire        [lr_pkg::WIN_BITS-1:0]     csr_window_height
);

   localparam int C       = COORD_BITS;
   localparam int DecBits = COORD_BITS + 2;
   localparam int PyCalc  = ((lr_pkg::WIN_BITS > COORD_BITS) ? lr_pkg::WIN_BITS : COORD_BITS) + 1;

   // line state
   logic                      running_ff, running_in;
   logic                      axes_swapped_ff, axes_swapped_in;
   logic [C-1:0]              major_pos_ff, major_pos_in;
   logic [C-1:0]              minor_pos_ff, minor_pos_in;
   logic [C-1:0]              major_stop_ff, major_stop_in;
   logic                      major_negative_ff, major_negative_in;
   logic                      minor_negative_ff, minor_negative_in;
   logic [DecBits-1:0]        decision_ff, decision_in;
   logic [C:0]                step_straight_ff, step_straight_in;
   logic [DecBits-1:0]        step_diagonal_ff, step_diagonal_in;

   logic [lr_pkg::WIN_BITS-1:0] window_height_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]              rsp_pixel_x_ff, rsp_pixel_x_in;
   logic [C:0]                rsp_pixel_y_ff, rsp_pixel_y_in;
   logic                      rsp_last_pixel_ff, rsp_last_pixel_in;

   logic                      accept;
   lr_pkg::action_type        action;

   // load setup
   logic [C:0]                dx, dy, dx_neg, dy_neg;
   logic [C-1:0]              span_x, span_y, dmaj, dmin;
   logic                      swap;
   logic                      degenerate;

   // step datapath
   logic                      go_diag;
   logic [DecBits-1:0]        dec_add;
   logic [C-1:0]              major_step, minor_step;

   // pixel
   logic                      emit;
   logic [C-1:0]              emit_x, emit_y;
   logic                      emit_last;
   logic [PyCalc-1:0]         py_full;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign action    = lr_pkg::action_type'(req_action);
   assign csr_ready = 1'b1;

   assign dx     = {1'b0, req_x_end} - {1'b0, req_x_start};
   assign dy     = {1'b0, req_y_end} - {1'b0, req_y_start};
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign span_x = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
   assign span_y = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
   assign swap   = span_x < span_y;
   assign dmaj   = swap ? span_y : span_x;
   assign dmin   = swap ? span_x : span_y;
   assign degenerate = (req_x_start == req_x_end) && (req_y_start == req_y_end);

   assign go_diag    = ~decision_ff[DecBits-1] && (decision_ff != '0);
   assign dec_add    = go_diag ? step_diagonal_ff : {1'b0, step_straight_ff};
   assign major_step = major_negative_ff ? major_pos_ff - C'(1) : major_pos_ff + C'(1);
   assign minor_step = ~go_diag ? minor_pos_ff
                     : (minor_negative_ff ? minor_pos_ff - C'(1) : minor_pos_ff + C'(1));

   always_comb begin
      running_in        = running_ff;
      axes_swapped_in   = axes_swapped_ff;
      major_pos_in      = major_pos_ff;
      minor_pos_in      = minor_pos_ff;
      major_stop_in     = major_stop_ff;
      major_negative_in = major_negative_ff;
      minor_negative_in = minor_negative_ff;
      decision_in       = decision_ff;
      step_straight_in  = step_straight_ff;
      step_diagonal_in  = step_diagonal_ff;
      emit              = 1'b0;
      emit_x            = req_x_start;
      emit_y            = req_y_start;
      emit_last         = degenerate;
      if (accept) begin
         unique case (action)
            lr_pkg::ACTION_LOAD: begin
               emit              = 1'b1;
               running_in        = ~degenerate;
               axes_swapped_in   = swap;
               major_pos_in      = swap ? req_y_start : req_x_start;
               minor_pos_in      = swap ? req_x_start : req_y_start;
               major_stop_in     = swap ? req_y_end : req_x_end;
               major_negative_in = swap ? dy[C] : dx[C];
               minor_negative_in = swap ? dx[C] : dy[C];
               decision_in       = {1'b0, dmin, 1'b0} - {2'b00, dmaj};
               step_straight_in  = {dmin, 1'b0};
               step_diagonal_in  = {1'b0, dmin, 1'b0} - {1'b0, dmaj, 1'b0};
            end
            lr_pkg::ACTION_STEP: begin
               if (running_ff) begin
                  emit         = 1'b1;
                  decision_in  = decision_ff + dec_add;
                  major_pos_in = major_step;
                  minor_pos_in = minor_step;
                  emit_x       = axes_swapped_ff ? minor_step : major_step;
                  emit_y       = axes_swapped_ff ? major_step : minor_step;
                  emit_last    = major_step == major_stop_ff;
                  running_in   = major_step != major_stop_ff;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   assign py_full = PyCalc'(window_height_ff) - PyCalc'(emit_y);

   assign rsp_valid_in      = accept ? emit : rsp_valid_ff & rsp_stall;
   assign rsp_pixel_x_in    = emit_x;
   assign rsp_pixel_y_in    = py_full[C:0];
   assign rsp_last_pixel_in = emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff        <= 1'b0;
         axes_swapped_ff   <= 1'b0;
         major_pos_ff      <= '0;
         minor_pos_ff      <= '0;
         major_stop_ff     <= '0;
         major_negative_ff <= 1'b0;
         minor_negative_ff <= 1'b0;
         decision_ff       <= '0;
         step_straight_ff  <= '0;
         step_diagonal_ff  <= '0;
         window_height_ff  <= lr_pkg::WIN_HEIGHT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         running_ff        <= running_in;
         axes_swapped_ff   <= axes_swapped_in;
         major_pos_ff      <= major_pos_in;
         minor_pos_ff      <= minor_pos_in;
         major_stop_ff     <= major_stop_in;
         major_negative_ff <= major_negative_in;
         minor_negative_ff <= minor_negative_in;
         decision_ff       <= decision_in;
         step_straight_ff  <= step_straight_in;
         step_diagonal_ff  <= step_diagonal_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            window_height_ff <= csr_window_height;
         end
      end
   end

   // pixel holding register
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_pixel_x_ff    <= rsp_pixel_x_in;
         rsp_pixel_y_ff    <= rsp_pixel_y_in;
         rsp_last_pixel_ff <= rsp_last_pixel_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_pixel_x_ff;
   assign rsp_pixel_y    = rsp_pixel_y_ff;
   assign rsp_last_pixel = rsp_last_pixel_ff;

endmodule

`default_nettype wire

// ===== verif/line_rasterizer_checker.sv =====
module line_rasterizer_checker
   import lr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,

   input  wire                          req_valid,
   input  wire                          req_stall,
   input  wire                          req_action,
   input  wire  [COORD_BITS-1:0]        req_x_start,
   input  wire  [COORD_BITS-1:0]        req_y_start,
   input  wire  [COORD_BITS-1:0]        req_x_end,
   input  wire  [COORD_BITS-1:0]        req_y_end,

   input  wire                          rsp_valid,
   input  wire                          rsp_stall,
   input  wire  [COORD_BITS-1:0]        rsp_pixel_x,
   input  wire  signed [COORD_BITS:0]   rsp_pixel_y,
   input  wire                          rsp_last_pixel,

   input  wire                          csr_valid,
   input  wire                          csr_ready,
   input  wire  [WIN_BITS-1:0]          csr_window_height,

   output int                           pixel_errors,
   output int                           pixels_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_BITS-1:0]      x;
      logic signed [COORD_BITS:0] y;
      logic                       last;
   } pixel_type;

   pixel_type pixel_q[$];

   logic [WIN_BITS-1:0]          win_height;
   logic                         drawing;
   logic                         swapped;
   logic                         major_neg;
   logic                         minor_neg;
   logic [COORD_BITS-1:0]        major_pos;
   logic [COORD_BITS-1:0]        minor_pos;
   logic [COORD_BITS-1:0]        major_stop;
   logic signed [COORD_BITS+2:0] decision;
   logic [COORD_BITS+1:0]        straight_step;
   logic signed [COORD_BITS+2:0] diagonal_step;

   function automatic logic [COORD_BITS-1:0] advance(input logic [COORD_BITS-1:0] pos,
                                                      input logic neg);
      return neg ? pos - 1'b1 : pos + 1'b1;
   endfunction

   function automatic pixel_type current_pixel();
      pixel_type p;
      logic [COORD_BITS-1:0] raw_y;
      p.x = swapped ? minor_pos : major_pos;
      raw_y = swapped ? major_pos : minor_pos;
      p.y = (COORD_BITS+1)'(int'(win_height) - int'(raw_y));
      p.last = (major_pos == major_stop);
      return p;
   endfunction

   task automatic rasterize(input action_type act,
                            input logic [COORD_BITS-1:0] xs, ys, xe, ye);
      int dx, dy, span_x, span_y, dmaj, dmin;
      if (act == ACTION_LOAD) begin
         dx = int'(xe) - int'(xs);
         dy = int'(ye) - int'(ys);
         span_x = dx < 0 ? -dx : dx;
         span_y = dy < 0 ? -dy : dy;
         swapped = span_y > span_x;
         if (swapped) begin
            major_pos = ys;
            major_stop = ye;
            minor_pos = xs;
            major_neg = dy < 0;
            minor_neg = dx < 0;
            dmaj = span_y;
            dmin = span_x;
         end else begin
            major_pos = xs;
            major_stop = xe;
            minor_pos = ys;
            major_neg = dx < 0;
            minor_neg = dy < 0;
            dmaj = span_x;
            dmin = span_y;
         end
         decision = (COORD_BITS+3)'(2 * dmin - dmaj);
         straight_step = (COORD_BITS+2)'(2 * dmin);
         diagonal_step = (COORD_BITS+3)'(2 * dmin - 2 * dmaj);
         pixel_q = {pixel_q, current_pixel()};
         drawing = (major_pos != major_stop);
      end else if (drawing) begin
         if (decision <= 0) begin
            decision = decision + signed'({1'b0, straight_step});
         end else begin
            decision = decision + diagonal_step;
            minor_pos = advance(minor_pos, minor_neg);
         end
         major_pos = advance(major_pos, major_neg);
         pixel_q = {pixel_q, current_pixel()};
         if (major_pos == major_stop) begin
            drawing = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         win_height = WIN_HEIGHT_RESET;
         drawing = 1'b0;
         swapped = 1'b0;
         major_neg = 1'b0;
         minor_neg = 1'b0;
         major_pos = '0;
         minor_pos = '0;
         major_stop = '0;
         decision = '0;
         straight_step = '0;
         diagonal_step = '0;
         pixel_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pixel_x, rsp_pixel_y, rsp_last_pixel};
            if (pixel_q.size() == 0) begin
               $display("%0t: pixel with none expected: x=%0d y=%0d last=%0d",
                        $time, got.x, got.y, got.last);
               pixel_errors++;
            end else begin
               want = pixel_q.pop_front();
               if (got.x !== want.x) begin
                  $display("%0t: pixel_x mismatch: expected %0d, got %0d",
                           $time, want.x, got.x);
                  pixel_errors++;
               end
               if (got.y !== want.y) begin
                  $display("%0t: pixel_y mismatch: expected %0d, got %0d",
                           $time, want.y, got.y);
                  pixel_errors++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last_pixel mismatch: expected %0d, got %0d",
                           $time, want.last, got.last);
                  pixel_errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            win_height = csr_window_height;
         end
         if (req_valid && !req_stall) begin
            rasterize(action_type'(req_action), req_x_start, req_y_start, req_x_end, req_y_end);
         end
      end
      pixels_owed = pixel_q.size();
   end

endmodule

// ===== verif/line_rasterizer_top_tb.sv =====
module line_rasterizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lr_pkg::*;

   localparam int CB = COORD_BITS_DEFAULT;
   localparam int MAX_COORD = (1 << CB) - 1;
   localparam int MAX_HEIGHT = (1 << WIN_BITS) - 1;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 4;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_action = ACTION_STEP;
   logic [CB-1:0]       req_x_start = '0;
   logic [CB-1:0]       req_y_start = '0;
   logic [CB-1:0]       req_x_end = '0;
   logic [CB-1:0]       req_y_end = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CB-1:0]       rsp_pixel_x;
   logic signed [CB:0]  rsp_pixel_y;
   logic                rsp_last_pixel;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [WIN_BITS-1:0] csr_window_height = WIN_HEIGHT_RESET;

   int                  send_idle_pct = 18;
   int                  recv_idle_pct = 61;
   int                  pixel_errors;
   int                  pixels_owed;
   int                  quiet_cycles = 0;

   // zero picks a random height
   int unsigned         heights[9] = '{4095, 1, 0, 2048, 4095, 0, 1, 700, 0};

   line_rasterizer_top #(.COORD_BITS(CB)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_height (csr_window_height)
   );

   line_rasterizer_checker #(.COORD_BITS(CB)) pixel_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_height (csr_window_height),
      .pixel_errors      (pixel_errors),
      .pixels_owed       (pixels_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CB-1:0] any_coord();
      case ($urandom_range(7))
         0: return '0;
         1: return CB'(MAX_COORD);
         default: return CB'($urandom_range(MAX_COORD));
      endcase
   endfunction

   function automatic logic [CB-1:0] near_coord(input logic [CB-1:0] base, input int radius);
      int v;
      v = int'(base) + int'($urandom_range(2 * radius)) - radius;
      if (v < 0) v = 0;
      if (v > MAX_COORD) v = MAX_COORD;
      return CB'(v);
   endfunction

   task automatic send_req(input action_type act, input logic [CB-1:0] xs, ys, xe, ye);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end <= xe;
      req_y_end <= ye;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_line(input logic [CB-1:0] xs, ys, xe, ye);
      send_req(ACTION_LOAD, xs, ys, xe, ye);
   endtask

   // coordinate fields are don't-care on a step, so they carry noise
   task automatic step_line(input int count);
      repeat (count) begin
         send_req(ACTION_STEP, any_coord(), any_coord(), any_coord(), any_coord());
      end
   endtask

   // hold off until every pixel owed has arrived and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pixels_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_height(input logic [WIN_BITS-1:0] height);
      csr_valid <= 1'b1;
      csr_window_height <= height;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic draw_lines(input int budget);
      int issued, kind, radius, dx, dy, len, steps, extra;
      logic [CB-1:0] xs, ys, xe, ye;
      issued = 0;
      while (issued < budget) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_req(action_type'($urandom_range(1)), any_coord(), any_coord(),
                     any_coord(), any_coord());
            issued++;
         end else begin
            xs = any_coord();
            ys = any_coord();
            if (kind < 20) begin
               xe = any_coord();
               ye = any_coord();
            end else begin
               radius = ($urandom_range(9) == 0) ? 60 : 12;
               xe = near_coord(xs, radius);
               ye = near_coord(ys, radius);
            end
            dx = int'(xe) - int'(xs);
            dy = int'(ye) - int'(ys);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            len = dx > dy ? dx : dy;
            // long lines are cut short by the next load
            steps = (len > 128) ? $urandom_range(1, 24) : len;
            extra = 0;
            case ($urandom_range(9))
               0: if (steps > 0) steps = $urandom_range(0, steps - 1);
               1: extra = $urandom_range(1, 2);
               default: ;
            endcase
            load_line(xs, ys, xe, ye);
            step_line(steps);
            issued += 1 + steps;
            step_line(extra);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      step_line(1);
      load_line(CB'(7), CB'(7), CB'(7), CB'(7));
      step_line(1);
      load_line('0, '0, CB'(MAX_COORD), CB'(MAX_COORD));
      step_line(2);
      load_line(CB'(MAX_COORD), CB'(MAX_COORD), '0, '0);
      step_line(1);
      load_line('0, CB'(MAX_COORD), CB'(MAX_COORD), '0);
      step_line(1);
      load_line(CB'(MAX_COORD), '0, '0, CB'(MAX_COORD));
      load_line(CB'(10), CB'(10), CB'(11), CB'(14));
      step_line(5);
      load_line(CB'(20), CB'(3), CB'(17), CB'(3));
      step_line(3);
      load_line(CB'(100), CB'(200), CB'(100), CB'(197));
      step_line(3);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int k = 0; k < 3; k++) begin
            settle();
            if (heights[3 * phase + k] != 0) begin
               write_window_height(WIN_BITS'(heights[3 * phase + k]));
            end else begin
               write_window_height(WIN_BITS'($urandom_range(1, MAX_HEIGHT)));
            end
            draw_lines(190);
         end
      end

      settle();
      if (pixel_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lr_pkg.sv
rtl/line_rasterizer_top.sv
verif/line_rasterizer_checker.sv
verif/line_rasterizer_top_tb.sv
